/* design/arc_page_replacement_defines.svh */
// Assertion macros for the ARC page replacement block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ARC_PAGE_REPLACEMENT_DEFINES_SVH
`define ARC_PAGE_REPLACEMENT_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define ARC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("arc assertion failed");

// Trigger at one edge implies consequence at the next edge.
`define ARC_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("arc assertion failed");

`endif

/* design/arcpr_pkg.sv */
// Shared types and constants for the ARC page replacement block.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package arcpr_pkg;

  localparam int unsigned DirDepth = 128;
  localparam int unsigned MaxCap   = 64;
  localparam int unsigned IdxW     = 7;
  localparam int unsigned TagW     = 48;
  localparam int unsigned RecW     = 7;
  localparam int unsigned SizeW    = 8;
  localparam int unsigned CapW     = 7;
  localparam int unsigned TotW     = 10;

  typedef enum logic [2:0] {
    LIST_NONE = 3'd0,
    LIST_T1   = 3'd1,
    LIST_T2   = 3'd2,
    LIST_B1   = 3'd3,
    LIST_B2   = 3'd4
  } list_e;

  // where the cell select index comes from
  typedef enum logic [1:0] {
    SRC_HIT   = 2'd0,
    SRC_VIC   = 2'd1,
    SRC_GHOST = 2'd2,
    SRC_SLOT  = 2'd3
  } idx_src_e;

  // which list a push targets
  typedef enum logic [1:0] {
    PUSH_T1    = 2'd0,
    PUSH_T2    = 2'd1,
    PUSH_GHOST = 2'd2
  } push_src_e;

  typedef struct packed {
    logic      accept;
    logic      scan;
    logic      div_start;
    logic      div_step;
    logic      adapt;
    logic      choose;
    logic      trim;
    logic      pick;
    logic      sel;
    idx_src_e  src;
    logic      unlink;
    logic      push;
    push_src_e push_src;
    logic      tag_wr;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic              scan_done;
    list_e             hit_list;
    logic              div_done;
    logic              ev_ok;
    logic              need_evict;
    logic              trim_cond;
    logic              need_drop;
    logic              out_busy;
    logic [TotW-1:0]   total;
    logic [CapW-1:0]   target;
  } stat_t;

endpackage

/* design/arc_page_replacement.sv */
// Adaptive Replacement Cache directory for 128 tags (T1, T2, B1, B2 lists).
// Access words are handled one at a time: a sweep of the directory at one
// entry per cycle through the tag memory read port finds the hit, the free
// slot and the LRU entry of every list; a ghost hit adds an 8-step divider
// and the target update; the list updates follow. Results leave through a
// register, so the next word is taken while one waits.
// Depends on arcpr_pkg, arcpr_ctrl, arcpr_datapath and the defines header.
`timescale 1ns / 1ps
`include "arc_page_replacement_defines.svh"

module arc_page_replacement (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [arcpr_pkg::TagW-1:0]  page_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        miss_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [arcpr_pkg::CapW-1:0]  capacity_i
);

  arcpr_pkg::cmd_t  dp_cmd;
  arcpr_pkg::stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  arcpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  arcpr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .page_number_i (page_number_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .capacity_i    (capacity_i),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .miss_o        (miss_o)
  );

  `ARC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `ARC_ASSERT_NEXT(a_result_loaded, dp_cmd.out_load, out_valid_o)
  `ARC_ASSERT_ALWAYS(a_dir_bound, dp_stat.total <= arcpr_pkg::DirDepth)
  `ARC_ASSERT_ALWAYS(a_target_bound, dp_stat.target <= arcpr_pkg::MaxCap)

endmodule

/* design/arcpr_datapath.sv */
// Datapath of the ARC page replacement block: tag memory, list/rank cells,
// list sizes, adaptive target, divider and result register. Uses arcpr_pkg.
`timescale 1ns / 1ps

module arcpr_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [arcpr_pkg::TagW-1:0]  page_number_i,
  input  logic                        cfg_we_i,
  input  logic [arcpr_pkg::CapW-1:0]  capacity_i,
  input  arcpr_pkg::cmd_t             cmd_i,
  output arcpr_pkg::stat_t            stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        miss_o
);

  localparam int unsigned IdxW  = arcpr_pkg::IdxW;
  localparam int unsigned RecW  = arcpr_pkg::RecW;
  localparam int unsigned SizeW = arcpr_pkg::SizeW;
  localparam int unsigned CapW  = arcpr_pkg::CapW;
  localparam int unsigned TotW  = arcpr_pkg::TotW;
  localparam int unsigned Depth = arcpr_pkg::DirDepth;

  // storage
  logic [arcpr_pkg::TagW-1:0] tag_mem [Depth];
  arcpr_pkg::list_e           list_q  [Depth];
  logic [RecW-1:0]            rec_q   [Depth];
  logic [SizeW-1:0]           size_q  [4];
  logic [CapW-1:0]            cap_q, target_q;

  logic [arcpr_pkg::TagW-1:0] page_q, rd_tag_q;
  logic [IdxW:0]              scan_cnt_q;
  logic                       rd_vld_q;
  logic [IdxW-1:0]            rd_idx_q;
  arcpr_pkg::list_e           rd_list_q;
  logic [RecW-1:0]            rd_rec_q;

  logic                       hit_fnd_q, free_fnd_q;
  logic [IdxW-1:0]            hit_idx_q, free_idx_q;
  arcpr_pkg::list_e           hit_list_q;
  logic [IdxW-1:0]            lru_q [4];

  logic [SizeW-1:0]           div_num_q, div_den_q, div_rem_q;
  logic [3:0]                 div_cnt_q;

  arcpr_pkg::list_e           vic_list_q;
  logic [IdxW-1:0]            vic_idx_q, slot_idx_q, sel_idx_q;
  logic                       vic_ok_q, bo_ne_q, trim_q;
  arcpr_pkg::list_e           sel_list_q;
  logic [RecW-1:0]            sel_rec_q;
  logic                       out_valid_q, miss_q;

  // ---------------- combinational helpers ----------------
  logic [CapW-1:0]   cap_eff;
  logic [SizeW-1:0]  t1, t2, b1, b2;
  logic [TotW-1:0]   total;
  logic              need_evict, trim_cond, ev_ok, is_ghost;
  arcpr_pkg::list_e  o_pref, o_fin, push_list;
  logic [IdxW-1:0]   v_idx, ghost_idx, slot_idx, sel_idx, b1_cur, b2_cur;
  logic              bo_ne;
  logic [SizeW-1:0]  delta;
  logic [SizeW:0]    sum, div_t;
  logic [CapW-1:0]   target_d;

  assign cap_eff = (cap_q > CapW'(arcpr_pkg::MaxCap)) ? CapW'(arcpr_pkg::MaxCap) : cap_q;
  assign t1 = size_q[0];
  assign t2 = size_q[1];
  assign b1 = size_q[2];
  assign b2 = size_q[3];
  assign total = TotW'(t1) + TotW'(t2) + TotW'(b1) + TotW'(b2);
  assign need_evict = (TotW'(t1) + TotW'(t2)) >= TotW'(cap_eff);
  assign trim_cond  = total >= (TotW'(cap_eff) << 1);
  assign ev_ok      = (t1 != '0) || (t2 != '0);
  assign is_ghost   = (hit_list_q == arcpr_pkg::LIST_B1) || (hit_list_q == arcpr_pkg::LIST_B2);

  // victim list choice
  always_comb begin
    if (t1 > SizeW'(target_q)) begin
      o_pref = arcpr_pkg::LIST_T1;
    end else if (t1 < SizeW'(target_q)) begin
      o_pref = arcpr_pkg::LIST_T2;
    end else if (!is_ghost) begin
      o_pref = (t1 == '0) ? arcpr_pkg::LIST_T2 : arcpr_pkg::LIST_T1;
    end else begin
      o_pref = (t2 == '0) ? arcpr_pkg::LIST_T1 : arcpr_pkg::LIST_T2;
    end
    if (o_pref == arcpr_pkg::LIST_T1) begin
      o_fin = (t1 != '0) ? arcpr_pkg::LIST_T1 : arcpr_pkg::LIST_T2;
    end else begin
      o_fin = (t2 != '0) ? arcpr_pkg::LIST_T2 : arcpr_pkg::LIST_T1;
    end
    v_idx = (o_fin == arcpr_pkg::LIST_T1) ? lru_q[0] : lru_q[1];
    bo_ne = (o_fin == arcpr_pkg::LIST_T1) ? (b1 != '0) : (b2 != '0);
  end

  // ghost to trim: old LRU of the receiving ghost list, or the victim itself
  assign ghost_idx = bo_ne_q ? ((vic_list_q == arcpr_pkg::LIST_T1) ? lru_q[2] : lru_q[3])
                             : vic_idx_q;

  // current LRU of each ghost list after the eviction
  assign b1_cur = (vic_ok_q && vic_list_q == arcpr_pkg::LIST_T1 && !bo_ne_q) ? vic_idx_q
                                                                              : lru_q[2];
  assign b2_cur = (vic_ok_q && vic_list_q == arcpr_pkg::LIST_T2 && !bo_ne_q) ? vic_idx_q
                                                                              : lru_q[3];

  always_comb begin
    if (free_fnd_q) begin
      slot_idx = (trim_q && ghost_idx < free_idx_q) ? ghost_idx : free_idx_q;
    end else if (trim_q) begin
      slot_idx = ghost_idx;
    end else if (b1 != '0) begin
      slot_idx = b1_cur;
    end else if (b2 != '0) begin
      slot_idx = b2_cur;
    end else if (t1 != '0) begin
      slot_idx = lru_q[0];
    end else begin
      slot_idx = lru_q[1];
    end
  end

  always_comb begin
    case (cmd_i.src)
      arcpr_pkg::SRC_HIT:   sel_idx = hit_idx_q;
      arcpr_pkg::SRC_VIC:   sel_idx = vic_idx_q;
      arcpr_pkg::SRC_GHOST: sel_idx = ghost_idx;
      arcpr_pkg::SRC_SLOT:  sel_idx = slot_idx_q;
      default:              sel_idx = hit_idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.push_src)
      arcpr_pkg::PUSH_T1:    push_list = arcpr_pkg::LIST_T1;
      arcpr_pkg::PUSH_T2:    push_list = arcpr_pkg::LIST_T2;
      arcpr_pkg::PUSH_GHOST: push_list = (vic_list_q == arcpr_pkg::LIST_T1) ?
                                         arcpr_pkg::LIST_B1 : arcpr_pkg::LIST_B2;
      default:               push_list = arcpr_pkg::LIST_T2;
    endcase
  end

  // target adaptation
  assign delta = (div_num_q == '0) ? SizeW'(1) : div_num_q;
  assign sum   = (SizeW+1)'(target_q) + (SizeW+1)'(delta);
  always_comb begin
    if (hit_list_q == arcpr_pkg::LIST_B1) begin
      target_d = (sum > (SizeW+1)'(cap_eff)) ? cap_eff : sum[CapW-1:0];
    end else begin
      target_d = (SizeW'(target_q) > delta) ? (target_q - delta[CapW-1:0]) : '0;
    end
  end

  assign div_t = {div_rem_q, div_num_q[SizeW-1]};

  // ---------------- tag memory ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.tag_wr) begin
      tag_mem[sel_idx_q] <= page_q;
    end
    if (cmd_i.scan && !scan_cnt_q[IdxW]) begin
      rd_tag_q <= tag_mem[scan_cnt_q[IdxW-1:0]];
    end
  end

  // ---------------- list / rank cells ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Depth; j++) begin
        list_q[j] <= arcpr_pkg::LIST_NONE;
        rec_q[j]  <= '0;
      end
    end else begin
      for (int j = 0; j < Depth; j++) begin
        if (cmd_i.unlink) begin
          if (IdxW'(j) == sel_idx_q) begin
            list_q[j] <= arcpr_pkg::LIST_NONE;
            rec_q[j]  <= '0;
          end else if (list_q[j] == sel_list_q && rec_q[j] > sel_rec_q) begin
            rec_q[j] <= rec_q[j] - RecW'(1);
          end
        end else if (cmd_i.push) begin
          if (IdxW'(j) == sel_idx_q) begin
            list_q[j] <= push_list;
            rec_q[j]  <= '0;
          end else if (list_q[j] == push_list) begin
            rec_q[j] <= rec_q[j] + RecW'(1);
          end
        end
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapW'(arcpr_pkg::MaxCap);
      target_q    <= '0;
      for (int l = 0; l < 4; l++) begin
        size_q[l] <= '0;
      end
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      hit_fnd_q   <= 1'b0;
      hit_list_q  <= arcpr_pkg::LIST_NONE;
      free_fnd_q  <= 1'b0;
      div_cnt_q   <= '0;
      vic_ok_q    <= 1'b0;
      trim_q      <= 1'b0;
      vic_list_q  <= arcpr_pkg::LIST_T1;
      sel_list_q  <= arcpr_pkg::LIST_NONE;
      rd_list_q   <= arcpr_pkg::LIST_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= capacity_i;
      end
      if (cmd_i.accept) begin
        scan_cnt_q <= '0;
        rd_vld_q   <= 1'b0;
        hit_fnd_q  <= 1'b0;
        hit_list_q <= arcpr_pkg::LIST_NONE;
        free_fnd_q <= 1'b0;
        vic_ok_q   <= 1'b0;
        trim_q     <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (!scan_cnt_q[IdxW]) begin
          rd_list_q  <= list_q[scan_cnt_q[IdxW-1:0]];
          scan_cnt_q <= scan_cnt_q + (IdxW+1)'(1);
          rd_vld_q   <= 1'b1;
        end else begin
          rd_vld_q <= 1'b0;
        end
        if (rd_vld_q) begin
          if (rd_list_q != arcpr_pkg::LIST_NONE && rd_tag_q == page_q && !hit_fnd_q) begin
            hit_fnd_q  <= 1'b1;
            hit_list_q <= rd_list_q;
          end
          if (rd_list_q == arcpr_pkg::LIST_NONE && !free_fnd_q) begin
            free_fnd_q <= 1'b1;
          end
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= 4'd8;
      end else if (cmd_i.div_step && div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 4'd1;
      end
      if (cmd_i.adapt) begin
        target_q <= target_d;
      end
      if (cmd_i.choose) begin
        vic_ok_q   <= ev_ok;
        vic_list_q <= o_fin;
      end
      if (cmd_i.trim) begin
        trim_q <= trim_cond;
      end
      if (cmd_i.sel) begin
        sel_list_q <= list_q[sel_idx];
      end
      if (cmd_i.unlink) begin
        case (sel_list_q)
          arcpr_pkg::LIST_T1: if (t1 != '0) size_q[0] <= t1 - SizeW'(1);
          arcpr_pkg::LIST_T2: if (t2 != '0) size_q[1] <= t2 - SizeW'(1);
          arcpr_pkg::LIST_B1: if (b1 != '0) size_q[2] <= b1 - SizeW'(1);
          arcpr_pkg::LIST_B2: if (b2 != '0) size_q[3] <= b2 - SizeW'(1);
          default: ;
        endcase
      end else if (cmd_i.push) begin
        case (push_list)
          arcpr_pkg::LIST_T1: size_q[0] <= t1 + SizeW'(1);
          arcpr_pkg::LIST_T2: size_q[1] <= t2 + SizeW'(1);
          arcpr_pkg::LIST_B1: size_q[2] <= b1 + SizeW'(1);
          arcpr_pkg::LIST_B2: size_q[3] <= b2 + SizeW'(1);
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q <= page_number_i;
    end
    if (cmd_i.scan) begin
      if (!scan_cnt_q[IdxW]) begin
        rd_idx_q <= scan_cnt_q[IdxW-1:0];
        rd_rec_q <= rec_q[scan_cnt_q[IdxW-1:0]];
      end
      if (rd_vld_q) begin
        if (rd_list_q != arcpr_pkg::LIST_NONE && rd_tag_q == page_q && !hit_fnd_q) begin
          hit_idx_q <= rd_idx_q;
        end
        if (rd_list_q == arcpr_pkg::LIST_NONE && !free_fnd_q) begin
          free_idx_q <= rd_idx_q;
        end
        // the least recent member of a list holds rank size-1
        for (int l = 0; l < 4; l++) begin
          if (rd_list_q == arcpr_pkg::list_e'(l + 1) &&
              SizeW'(rd_rec_q) == size_q[l] - SizeW'(1)) begin
            lru_q[l] <= rd_idx_q;
          end
        end
      end
    end
    if (cmd_i.div_start) begin
      div_num_q <= (hit_list_q == arcpr_pkg::LIST_B1) ? b2 : b1;
      if (hit_list_q == arcpr_pkg::LIST_B1) begin
        div_den_q <= (b1 == '0) ? SizeW'(1) : b1;
      end else begin
        div_den_q <= (b2 == '0) ? SizeW'(1) : b2;
      end
      div_rem_q <= '0;
    end else if (cmd_i.div_step && div_cnt_q != '0) begin
      // restoring division, quotient shifts into the numerator register
      if (div_t >= (SizeW+1)'(div_den_q)) begin
        div_rem_q <= SizeW'(div_t - (SizeW+1)'(div_den_q));
        div_num_q <= {div_num_q[SizeW-2:0], 1'b1};
      end else begin
        div_rem_q <= div_t[SizeW-1:0];
        div_num_q <= {div_num_q[SizeW-2:0], 1'b0};
      end
    end
    if (cmd_i.choose) begin
      vic_idx_q <= v_idx;
      bo_ne_q   <= bo_ne;
    end
    if (cmd_i.pick) begin
      slot_idx_q <= slot_idx;
    end
    if (cmd_i.sel) begin
      sel_idx_q <= sel_idx;
      sel_rec_q <= rec_q[sel_idx];
    end
    if (cmd_i.out_load) begin
      miss_q <= !((hit_list_q == arcpr_pkg::LIST_T1) || (hit_list_q == arcpr_pkg::LIST_T2));
    end
  end

  assign out_valid_o = out_valid_q;
  assign miss_o      = miss_q;

  always_comb begin
    stat_o            = '0;
    stat_o.scan_done  = scan_cnt_q[IdxW] && !rd_vld_q;
    stat_o.hit_list   = hit_list_q;
    stat_o.div_done   = (div_cnt_q == '0);
    stat_o.ev_ok      = ev_ok;
    stat_o.need_evict = need_evict;
    stat_o.trim_cond  = trim_cond;
    stat_o.need_drop  = !free_fnd_q && !trim_q;
    stat_o.out_busy   = out_valid_q && !out_ready_i;
    stat_o.total      = total;
    stat_o.target     = target_q;
  end

endmodule

/* design/arcpr_ctrl.sv */
// Controller state machine of the ARC page replacement block.
// Sequences datapath commands per access word; uses arcpr_pkg.
`timescale 1ns / 1ps

module arcpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  arcpr_pkg::stat_t stat_i,
  output arcpr_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SCAN   = 5'd1;
  localparam logic [4:0] S_DECIDE = 5'd2;
  localparam logic [4:0] S_DIVW   = 5'd3;
  localparam logic [4:0] S_ADAPT  = 5'd4;
  localparam logic [4:0] S_CHOOSE = 5'd5;
  localparam logic [4:0] S_VSEL   = 5'd6;
  localparam logic [4:0] S_VUNL   = 5'd7;
  localparam logic [4:0] S_VPUSH  = 5'd8;
  localparam logic [4:0] S_TRIM   = 5'd9;
  localparam logic [4:0] S_GSEL   = 5'd10;
  localparam logic [4:0] S_GUNL   = 5'd11;
  localparam logic [4:0] S_FREE   = 5'd12;
  localparam logic [4:0] S_SSEL   = 5'd13;
  localparam logic [4:0] S_SUNL   = 5'd14;
  localparam logic [4:0] S_SSEL2  = 5'd15;
  localparam logic [4:0] S_SPUSH  = 5'd16;
  localparam logic [4:0] S_HSEL   = 5'd17;
  localparam logic [4:0] S_HUNL   = 5'd18;
  localparam logic [4:0] S_HPUSH  = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [4:0] state_q, state_d;
  logic       is_ghost;

  assign is_ghost = (stat_i.hit_list == arcpr_pkg::LIST_B1) ||
                    (stat_i.hit_list == arcpr_pkg::LIST_B2);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        case (stat_i.hit_list)
          arcpr_pkg::LIST_T1, arcpr_pkg::LIST_T2: state_d = S_HSEL;
          arcpr_pkg::LIST_B1, arcpr_pkg::LIST_B2: begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIVW;
          end
          default: state_d = stat_i.need_evict ? S_CHOOSE : S_FREE;
        endcase
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          state_d = S_ADAPT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_ADAPT: begin
        cmd_o.adapt = 1'b1;
        state_d     = S_CHOOSE;
      end
      S_CHOOSE: begin
        cmd_o.choose = 1'b1;
        if (stat_i.ev_ok) begin
          state_d = S_VSEL;
        end else begin
          state_d = is_ghost ? S_HSEL : S_FREE;
        end
      end
      S_VSEL: begin
        cmd_o.sel = 1'b1;
        cmd_o.src = arcpr_pkg::SRC_VIC;
        state_d   = S_VUNL;
      end
      S_VUNL: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_VPUSH;
      end
      S_VPUSH: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_src = arcpr_pkg::PUSH_GHOST;
        state_d        = is_ghost ? S_HSEL : S_TRIM;
      end
      S_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d    = stat_i.trim_cond ? S_GSEL : S_FREE;
      end
      S_GSEL: begin
        cmd_o.sel = 1'b1;
        cmd_o.src = arcpr_pkg::SRC_GHOST;
        state_d   = S_GUNL;
      end
      S_GUNL: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_FREE;
      end
      S_FREE: begin
        cmd_o.pick = 1'b1;
        state_d    = stat_i.need_drop ? S_SSEL : S_SSEL2;
      end
      S_SSEL: begin
        cmd_o.sel = 1'b1;
        cmd_o.src = arcpr_pkg::SRC_SLOT;
        state_d   = S_SUNL;
      end
      S_SUNL: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_SSEL2;
      end
      S_SSEL2: begin
        cmd_o.sel = 1'b1;
        cmd_o.src = arcpr_pkg::SRC_SLOT;
        state_d   = S_SPUSH;
      end
      S_SPUSH: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_src = arcpr_pkg::PUSH_T1;
        cmd_o.tag_wr   = 1'b1;
        state_d        = S_OUT;
      end
      S_HSEL: begin
        cmd_o.sel = 1'b1;
        cmd_o.src = arcpr_pkg::SRC_HIT;
        state_d   = S_HUNL;
      end
      S_HUNL: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_HPUSH;
      end
      S_HPUSH: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_src = arcpr_pkg::PUSH_T2;
        state_d        = S_OUT;
      end
      S_OUT: begin
        // wait until the result register is free
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
